### rtl/core/min_priority_queue_unsorted_array_top_defines.svh
// Assertion macros for the priority queue RTL.
// No dependencies; included by the top level, which carries the assertions.
`ifndef MIN_PRIORITY_QUEUE_UNSORTED_ARRAY_TOP_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_UNSORTED_ARRAY_TOP_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define MPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define MPQ_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### rtl/core/mpq_pkg.sv
// Types and constants for the minimum priority queue.
// No dependencies; used by the top level.
package mpq_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LIST   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic signed [DATA_W-1:0] EMPTY_MIN = -32'sd1;

   typedef struct packed {
      logic [1:0]               mode;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] item_value;
      logic signed [DATA_W-1:0] min_value;
      logic [COUNT_W-1:0]       count;
      logic                     last;
   } rsp_type;

endpackage

### rtl/core/mpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/min_priority_queue_unsorted_array_top.sv
// Minimum priority queue over an unsorted store of signed 32-bit values.
// Channels: req (mode, value) and rsp (status, item_value, min_value, count,
// last), both valid/ready; a transaction moves when valid and ready are high.
// Insert, and every error or unused-mode request, gives its single response
// in the cycle after acceptance and can be taken every cycle while the
// receiver takes each response. Remove-min with n stored values makes two
// passes over the store RAM, one read per cycle: a scan for the first
// minimum, then a pass that shifts later entries down and finds the new
// minimum. List makes one pass over the store per listed value, each pass
// picking the next value in (value, index) order. Each pass reads one entry
// at a time through the single RAM read port. Requests are taken only while
// no operation is in progress.
// Reset empties the queue (count to zero); RAM contents are not cleared.
// A stalled receiver holds the response register; a new request may still be
// accepted as the register drains, and a list pauses until it is taken.
// Depends on mpq_pkg, mpq_ram and the defines header.
`include "min_priority_queue_unsorted_array_top_defines.svh"

module min_priority_queue_unsorted_array_top #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mpq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mpq_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_LIST  = 3'd3;
   localparam logic [2:0] S_LEMIT = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [31:0] min_ff, min_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              p_vld_ff;
   logic [ADDR_W-1:0] p_idx_ff;
   logic signed [31:0] best_val_ff, best_val_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic              best_found_ff, best_found_in;
   logic signed [31:0] acc_val_ff, acc_val_in;
   logic              acc_found_ff, acc_found_in;
   logic signed [31:0] prev_val_ff, prev_val_in;
   logic [ADDR_W-1:0] prev_idx_ff, prev_idx_in;
   logic [CNT_W-1:0]  emitted_ff, emitted_in;
   logic              rsp_vld_ff;
   mpq_pkg::rsp_type  rsp_data_ff;

   logic              rsp_load;
   mpq_pkg::rsp_type  rsp_next;
   logic              req_fire;
   logic              rd_en;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [31:0]       ram_wdata;
   logic signed [31:0] rd_data;
   logic [ADDR_W-1:0] last_idx;
   logic              full;
   logic signed [31:0] cur_min;
   logic signed [31:0] ins_min;
   logic [CNT_W-1:0]  cnt_dec;
   logic [CNT_W-1:0]  emitted_inc;
   logic              list_cand;

   function automatic mpq_pkg::rsp_type make_rsp(
      input logic [1:0]         status,
      input logic signed [31:0] item,
      input logic signed [31:0] minv,
      input logic [CNT_W-1:0]   cnt,
      input logic               last
   );
      mpq_pkg::rsp_type r;
      r.status     = status;
      r.item_value = item;
      r.min_value  = (cnt == '0) ? mpq_pkg::EMPTY_MIN : minv;
      r.count      = mpq_pkg::COUNT_W'(cnt);
      r.last       = last;
      return r;
   endfunction

   mpq_ram #(
      .WIDTH(32),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (rd_en),
      .raddr (rd_idx_ff[ADDR_W-1:0]),
      .rdata (rd_data)
   );

   assign req_ready   = (state_ff == S_IDLE) && (!rsp_vld_ff || rsp_ready);
   assign req_fire    = req_valid && req_ready;
   assign full        = (cnt_ff == CNT_W'(CAPACITY));
   assign cur_min     = min_ff;
   assign ins_min     = ((cnt_ff == '0) || (req_data.value < min_ff)) ? req_data.value
                                                                       : min_ff;
   assign cnt_dec     = cnt_ff - CNT_W'(1);
   assign last_idx    = cnt_dec[ADDR_W-1:0];
   assign emitted_inc = emitted_ff + CNT_W'(1);
   assign rd_en       = ((state_ff == S_SCAN) || (state_ff == S_SHIFT) ||
                         (state_ff == S_LIST)) && (rd_idx_ff != cnt_ff);
   // strictly after the last listed (value, index) pair
   assign list_cand   = (emitted_ff == '0) || (rd_data > prev_val_ff) ||
                        ((rd_data == prev_val_ff) && (p_idx_ff > prev_idx_ff));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      min_in        = min_ff;
      rd_idx_in     = rd_en ? (rd_idx_ff + CNT_W'(1)) : rd_idx_ff;
      best_val_in   = best_val_ff;
      best_idx_in   = best_idx_ff;
      best_found_in = best_found_ff;
      acc_val_in    = acc_val_ff;
      acc_found_in  = acc_found_ff;
      prev_val_in   = prev_val_ff;
      prev_idx_in   = prev_idx_ff;
      emitted_in    = emitted_ff;
      rsp_load      = 1'b0;
      rsp_next      = '0;
      ram_we        = 1'b0;
      ram_waddr     = cnt_ff[ADDR_W-1:0];
      ram_wdata     = req_data.value;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_load = 1'b1;
               case (req_data.mode)
                  mpq_pkg::MODE_INSERT: begin
                     if (full) begin
                        rsp_next = make_rsp(mpq_pkg::ST_FULL, '0, cur_min, cnt_ff, 1'b1);
                     end else begin
                        ram_we   = 1'b1;
                        cnt_in   = cnt_ff + CNT_W'(1);
                        min_in   = ins_min;
                        rsp_next = make_rsp(mpq_pkg::ST_OK, '0, ins_min,
                                            cnt_ff + CNT_W'(1), 1'b1);
                     end
                  end
                  mpq_pkg::MODE_REMOVE, mpq_pkg::MODE_LIST: begin
                     if (cnt_ff == '0) begin
                        rsp_next = make_rsp(mpq_pkg::ST_EMPTY, '0, cur_min, cnt_ff, 1'b1);
                     end else begin
                        rsp_load      = 1'b0;
                        rd_idx_in     = '0;
                        best_found_in = 1'b0;
                        emitted_in    = '0;
                        state_in = (req_data.mode == mpq_pkg::MODE_REMOVE) ? S_SCAN
                                                                            : S_LIST;
                     end
                  end
                  default: begin
                     rsp_next = make_rsp(mpq_pkg::ST_OK, '0, cur_min, cnt_ff, 1'b1);
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (p_vld_ff) begin
               // strict compare keeps the first occurrence
               if (!best_found_ff || (rd_data < best_val_ff)) begin
                  best_val_in   = rd_data;
                  best_idx_in   = p_idx_ff;
                  best_found_in = 1'b1;
               end
               if (p_idx_ff == last_idx) begin
                  state_in     = S_SHIFT;
                  rd_idx_in    = '0;
                  acc_found_in = 1'b0;
               end
            end
         end

         S_SHIFT: begin
            if (p_vld_ff) begin
               if (p_idx_ff > best_idx_ff) begin
                  ram_we    = 1'b1;
                  ram_waddr = p_idx_ff - ADDR_W'(1);
                  ram_wdata = rd_data;
               end
               if ((p_idx_ff != best_idx_ff) &&
                   (!acc_found_ff || (rd_data < acc_val_ff))) begin
                  acc_val_in   = rd_data;
                  acc_found_in = 1'b1;
               end
               if (p_idx_ff == last_idx) begin
                  state_in = S_IDLE;
                  cnt_in   = cnt_dec;
                  min_in   = acc_val_in;
                  rsp_load = 1'b1;
                  rsp_next = make_rsp(mpq_pkg::ST_OK, best_val_ff, acc_val_in,
                                      cnt_dec, 1'b1);
               end
            end
         end

         S_LIST: begin
            if (p_vld_ff) begin
               if (list_cand && (!best_found_ff || (rd_data < best_val_ff))) begin
                  best_val_in   = rd_data;
                  best_idx_in   = p_idx_ff;
                  best_found_in = 1'b1;
               end
               if (p_idx_ff == last_idx) begin
                  state_in = S_LEMIT;
               end
            end
         end

         S_LEMIT: begin
            if (!rsp_vld_ff || rsp_ready) begin
               rsp_load    = 1'b1;
               rsp_next    = make_rsp(mpq_pkg::ST_OK, best_val_ff, cur_min, cnt_ff,
                                      emitted_inc == cnt_ff);
               prev_val_in = best_val_ff;
               prev_idx_in = best_idx_ff;
               emitted_in  = emitted_inc;
               if (emitted_inc == cnt_ff) begin
                  state_in = S_IDLE;
               end else begin
                  state_in      = S_LIST;
                  rd_idx_in     = '0;
                  best_found_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rd_idx_ff     <= '0;
         p_vld_ff      <= 1'b0;
         best_found_ff <= 1'b0;
         acc_found_ff  <= 1'b0;
         emitted_ff    <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rd_idx_ff     <= rd_idx_in;
         p_vld_ff      <= rd_en;
         best_found_ff <= best_found_in;
         acc_found_ff  <= acc_found_in;
         emitted_ff    <= emitted_in;
         rsp_vld_ff    <= rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
      end
   end

   always_ff @(posedge clock) begin
      min_ff      <= min_in;
      p_idx_ff    <= rd_idx_ff[ADDR_W-1:0];
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      acc_val_ff  <= acc_val_in;
      prev_val_ff <= prev_val_in;
      prev_idx_ff <= prev_idx_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   `MPQ_ASSERT_NEVER(a_cnt_bound, clock, reset, cnt_ff > CNT_W'(CAPACITY), "count above capacity")
   `MPQ_ASSERT_NEVER(a_rsp_overwrite, clock, reset, rsp_load && rsp_vld_ff && !rsp_ready, "pending transaction overwritten")
   `MPQ_ASSERT(a_rd_range, clock, reset, rd_en |-> (rd_idx_ff < cnt_ff), "read beyond stored entries")
   `MPQ_ASSERT(a_we_state, clock, reset, ram_we |-> ((state_ff == S_IDLE) || (state_ff == S_SHIFT)), "store written outside insert or shift")
   `MPQ_ASSERT(a_remove_dec, clock, reset, ((state_ff == S_SHIFT) && (state_in == S_IDLE)) |=> (cnt_ff == $past(cnt_dec)), "remove did not drop count by one")

endmodule
